// File: rtl/core/vpa_pkg.sv
// Shared definitions for the variable partition allocator.
// Holds the default sizes, status codes, controller states and the
// command and status structs between controller and datapath.
package vpa_pkg;

    localparam int VPA_MEM_UNITS   = 1024;
    localparam int VPA_OWNER_SLOTS = 16;
    localparam int VPA_FREE_SLOTS  = 17;

    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_ZERO    = 3'd2,
        ST_NOFIT   = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OSCAN,
        S_FSCAN,
        S_PSCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    oscan;
        logic    fscan;
        logic    pscan;
        logic    finish;
        logic    apply_alloc;
        logic    apply_rel;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic hit;
        logic slot_avail;
        logic size_zero;
        logic oscan_last;
        logic fscan_done;
        logic found;
        logic pscan_done;
        logic rel_full;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/variable_partition_allocator_unit.sv
// Top level of the variable partition allocator.
// Depends on vpa_pkg, vpa_ctrl and vpa_datapath.
//
// Each transaction on the slave stream is one allocate or release request and
// yields exactly one transaction on the master stream. A request walks the
// owner table one slot per cycle. An allocate then walks the free table one
// entry per cycle, up to the number of free regions, and fewer under first
// fit or when the owner exists or the size is zero. A release walks the free
// table up to the insertion point. The walk state then detects the end of
// that walk and the finish state applies the update and loads the result.
// The next request is accepted only after that finish state, so requests do
// not overlap; a single shared scan index serves all the walks. The next
// request is taken while a result still waits in the output register; the
// final cycle of a request stalls until that register is free. The fit
// policy is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module variable_partition_allocator_unit #(
    parameter int MEM_UNITS   = vpa_pkg::VPA_MEM_UNITS,
    parameter int OWNER_SLOTS = vpa_pkg::VPA_OWNER_SLOTS,
    parameter int FREE_SLOTS  = vpa_pkg::VPA_FREE_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,   // fit_policy
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // owner_id[7:0], request_size[18:8], zero pad
    input  logic [0:0]  s_tuser,     // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // block_start[9:0], block_size[20:10], zero pad
    output logic [2:0]  m_tuser      // status[2:0]
);
    import vpa_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    status_t    out_status;
    logic [9:0] out_start;
    logic [10:0] out_size;

    vpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vpa_datapath #(
        .MEM_UNITS   (MEM_UNITS),
        .OWNER_SLOTS (OWNER_SLOTS),
        .FREE_SLOTS  (FREE_SLOTS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_op      (s_tuser[0]),
        .in_id      (s_tdata[7:0]),
        .in_size    (s_tdata[18:8]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .m_tready   (m_tready),
        .cmd        (cmd),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_start  (out_start),
        .out_size   (out_size)
    );

    assign m_tdata = {3'b000, out_size, out_start};
    assign m_tuser = out_status;

endmodule

// File: rtl/core/vpa_ctrl.sv
// Controller state machine of the variable partition allocator.
// Depends on vpa_pkg; drives the datapath by cmd_t and reads sts_t.
module vpa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  vpa_pkg::sts_t sts,
    output vpa_pkg::cmd_t cmd
);
    import vpa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.code = ST_OK;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = S_OSCAN;
                end
            end
            S_OSCAN: begin
                cmd.oscan = 1'b1;
                if (sts.oscan_last) begin
                    state_next = (sts.op == OP_RELEASE) ? S_PSCAN : S_FSCAN;
                end
            end
            S_FSCAN: begin
                if (sts.hit || sts.size_zero || sts.fscan_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.fscan = 1'b1;
                end
            end
            S_PSCAN: begin
                if (!sts.hit || sts.pscan_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.pscan = 1'b1;
                end
            end
            S_FINISH: begin
                if (sts.op == OP_ALLOC) begin
                    if (sts.hit) cmd.code = ST_EXISTS;
                    else if (sts.size_zero) cmd.code = ST_ZERO;
                    else if (!sts.found) cmd.code = ST_NOFIT;
                    else if (!sts.slot_avail) cmd.code = ST_FULL;
                    else cmd.code = ST_OK;
                end else begin
                    if (!sts.hit) cmd.code = ST_UNKNOWN;
                    else if (sts.rel_full) cmd.code = ST_FULL;
                    else cmd.code = ST_OK;
                end
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    cmd.apply_alloc = (cmd.code == ST_OK) && (sts.op == OP_ALLOC);
                    cmd.apply_rel = (cmd.code == ST_OK) && (sts.op == OP_RELEASE);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/vpa_datapath.sv
// Datapath of the variable partition allocator: free and owner tables,
// scan registers, policy register and the result register.
// Depends on vpa_pkg; controlled by vpa_ctrl through cmd_t and sts_t.
module vpa_datapath #(
    parameter int MEM_UNITS   = vpa_pkg::VPA_MEM_UNITS,
    parameter int OWNER_SLOTS = vpa_pkg::VPA_OWNER_SLOTS,
    parameter int FREE_SLOTS  = vpa_pkg::VPA_FREE_SLOTS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_op,
    input  logic [7:0]       in_id,
    input  logic [10:0]      in_size,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             m_tready,
    input  vpa_pkg::cmd_t    cmd,
    output vpa_pkg::sts_t    sts,
    output logic             m_tvalid,
    output vpa_pkg::status_t out_status,
    output logic [9:0]       out_start,
    output logic [10:0]      out_size
);
    import vpa_pkg::*;

    localparam int MW = $clog2(MEM_UNITS + 1);
    localparam int W  = (MW > 11) ? MW : 11;
    localparam int MAXS = (OWNER_SLOTS > FREE_SLOTS) ? OWNER_SLOTS : FREE_SLOTS;
    localparam int IW = $clog2(MAXS + 1);
    localparam int FW = $clog2(FREE_SLOTS);
    localparam int OW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int CW = $clog2(FREE_SLOTS + 1);

    logic          policy_reg;
    logic          op_reg;
    logic [7:0]    id_reg;
    logic [W-1:0]  size_reg;
    logic [IW-1:0] idx_reg;
    logic          hit_reg, avail_reg, found_reg, stop_reg;
    logic [OW-1:0] slot_reg, hitslot_reg;
    logic [W-1:0]  s_reg, n_reg;
    logic [FW-1:0] pick_reg;
    logic [W-1:0]  pick_start_reg, pick_len_reg, best_reg;
    logic [W-1:0]  prev_end_reg, prev_len_reg;
    logic [W-1:0]  fstart_reg [FREE_SLOTS];
    logic [W-1:0]  flen_reg [FREE_SLOTS];
    logic [W-1:0]  fstart_next [FREE_SLOTS];
    logic [W-1:0]  flen_next [FREE_SLOTS];
    logic [CW-1:0] count_reg, count_next;
    logic [OWNER_SLOTS-1:0] ovalid_reg;
    logic [7:0]    otag_reg [OWNER_SLOTS];
    logic [W-1:0]  ostart_reg [OWNER_SLOTS];
    logic [W-1:0]  olen_reg [OWNER_SLOTS];
    logic          out_valid_reg;

    logic [OW-1:0] oidx;
    logic [FW-1:0] fidx, fidx_m1;
    logic [W-1:0]  cur_start, cur_len, cur_left;
    logic          in_range, cur_fit, left_adj, right_adj;
    logic          drop_en, ins_en;
    logic [FW-1:0] drop_at;

    assign oidx      = idx_reg[OW-1:0];
    assign fidx      = idx_reg[FW-1:0];
    assign fidx_m1   = fidx - 1'b1;
    assign cur_start = fstart_reg[fidx];
    assign cur_len   = flen_reg[fidx];
    assign cur_left  = cur_len - size_reg;
    assign cur_fit   = cur_len >= size_reg;
    assign in_range  = idx_reg < IW'(count_reg);
    assign left_adj  = (idx_reg != '0) && (prev_end_reg == s_reg);
    assign right_adj = in_range && ((s_reg + n_reg) == cur_start);

    assign sts.op         = op_reg;
    assign sts.hit        = hit_reg;
    assign sts.slot_avail = avail_reg;
    assign sts.size_zero  = (size_reg == '0);
    assign sts.oscan_last = (oidx == OW'(OWNER_SLOTS - 1));
    assign sts.fscan_done = !in_range || stop_reg;
    assign sts.found      = found_reg;
    assign sts.pscan_done = !in_range || (cur_start > s_reg);
    assign sts.rel_full   = !left_adj && !right_adj && (count_reg >= CW'(FREE_SLOTS));
    assign sts.out_free   = !out_valid_reg || m_tready;
    assign m_tvalid       = out_valid_reg;

    // Free table update: a drop shifts the entries above down by one, an
    // insert shifts them up, and merges or a carve rewrite a single entry.
    always_comb begin
        drop_en = 1'b0;
        ins_en  = 1'b0;
        drop_at = fidx;
        count_next = count_reg;
        for (int i = 0; i < FREE_SLOTS; i++) begin
            fstart_next[i] = fstart_reg[i];
            flen_next[i]   = flen_reg[i];
        end
        if (cmd.apply_alloc) begin
            drop_at = pick_reg;
            drop_en = (pick_len_reg == size_reg);
        end else if (cmd.apply_rel) begin
            drop_en = left_adj && right_adj;
            ins_en  = !left_adj && !right_adj;
        end
        if (drop_en) begin
            for (int i = 0; i < FREE_SLOTS - 1; i++) begin
                if (FW'(i) >= drop_at) begin
                    fstart_next[i] = fstart_reg[i + 1];
                    flen_next[i]   = flen_reg[i + 1];
                end
            end
            count_next = count_reg - 1'b1;
        end
        if (ins_en) begin
            for (int i = 1; i < FREE_SLOTS; i++) begin
                if (FW'(i) > fidx) begin
                    fstart_next[i] = fstart_reg[i - 1];
                    flen_next[i]   = flen_reg[i - 1];
                end
            end
            fstart_next[fidx] = s_reg;
            flen_next[fidx]   = n_reg;
            count_next = count_reg + 1'b1;
        end
        if (cmd.apply_alloc && !drop_en) begin
            fstart_next[pick_reg] = pick_start_reg + size_reg;
            flen_next[pick_reg]   = pick_len_reg - size_reg;
        end
        if (cmd.apply_rel) begin
            if (left_adj && right_adj) begin
                flen_next[fidx_m1] = prev_len_reg + n_reg + cur_len;
            end else if (left_adj) begin
                flen_next[fidx_m1] = prev_len_reg + n_reg;
            end else if (right_adj) begin
                fstart_next[fidx] = s_reg;
                flen_next[fidx]   = cur_len + n_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg    <= FIT_FIRST;
            out_valid_reg <= 1'b0;
            ovalid_reg    <= '0;
            count_reg     <= CW'(1);
            for (int i = 0; i < FREE_SLOTS; i++) begin
                fstart_reg[i] <= '0;
                flen_reg[i]   <= '0;
            end
            flen_reg[0] <= W'(MEM_UNITS);
        end else begin
            if (cfg_we) policy_reg <= cfg_wdata;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            for (int i = 0; i < FREE_SLOTS; i++) begin
                fstart_reg[i] <= fstart_next[i];
                flen_reg[i]   <= flen_next[i];
            end
            count_reg <= count_next;
            if (cmd.apply_alloc) ovalid_reg[slot_reg] <= 1'b1;
            if (cmd.apply_rel) ovalid_reg[hitslot_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= in_op;
            id_reg       <= in_id;
            size_reg     <= W'(in_size);
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            avail_reg    <= 1'b0;
            found_reg    <= 1'b0;
            stop_reg     <= 1'b0;
            prev_end_reg <= '0;
            prev_len_reg <= '0;
        end
        if (cmd.oscan) begin
            if (ovalid_reg[oidx] && (otag_reg[oidx] == id_reg)) begin
                hit_reg     <= 1'b1;
                hitslot_reg <= oidx;
                s_reg       <= ostart_reg[oidx];
                n_reg       <= olen_reg[oidx];
            end
            if (!ovalid_reg[oidx] && !avail_reg) begin
                avail_reg <= 1'b1;
                slot_reg  <= oidx;
            end
            idx_reg <= sts.oscan_last ? '0 : idx_reg + 1'b1;
        end
        if (cmd.fscan) begin
            if (cur_fit && (!found_reg || (policy_reg == FIT_BEST && cur_left < best_reg))) begin
                found_reg      <= 1'b1;
                pick_reg       <= fidx;
                pick_start_reg <= cur_start;
                pick_len_reg   <= cur_len;
                best_reg       <= cur_left;
                if (policy_reg == FIT_FIRST) stop_reg <= 1'b1;
            end
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.pscan) begin
            prev_end_reg <= cur_start + cur_len;
            prev_len_reg <= cur_len;
            idx_reg      <= idx_reg + 1'b1;
        end
        if (cmd.apply_alloc) begin
            otag_reg[slot_reg]   <= id_reg;
            ostart_reg[slot_reg] <= pick_start_reg;
            olen_reg[slot_reg]   <= size_reg;
        end
        if (cmd.finish) begin
            out_status <= cmd.code;
            if (cmd.code != ST_OK) begin
                out_start <= '0;
                out_size  <= '0;
            end else if (op_reg == OP_ALLOC) begin
                out_start <= pick_start_reg[9:0];
                out_size  <= size_reg[10:0];
            end else begin
                out_start <= s_reg[9:0];
                out_size  <= n_reg[10:0];
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(FREE_SLOTS))
        else $error("free table count beyond its depth");

    a_alloc_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply_alloc |-> (!hit_reg && found_reg && avail_reg && size_reg != '0))
        else $error("allocation applied without a legal fit and slot");

    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply_rel |=> !ovalid_reg[$past(hitslot_reg)])
        else $error("released owner slot still valid");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");

endmodule

// File: tb/variable_partition_allocator_unit_checker.sv
// Checker for the variable partition allocator: watches both streams,
// predicts each result from its own copy of the free and owner tables.
// Depends on vpa_pkg.
module variable_partition_allocator_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          pending
);
    import vpa_pkg::*;

    typedef struct {
        status_t    status;
        logic [9:0] start;
        logic [10:0] size;
    } alloc_result_t;

    alloc_result_t expected_q[$];
    logic        policy;
    int          fstart [VPA_FREE_SLOTS];
    int          flen   [VPA_FREE_SLOTS];
    int          fcount;
    logic [7:0]  otag   [VPA_OWNER_SLOTS];
    int          ostart [VPA_OWNER_SLOTS];
    int          olen   [VPA_OWNER_SLOTS];
    logic        ovalid [VPA_OWNER_SLOTS];

    assign pending = expected_q.size();

    function automatic int find_owner(logic [7:0] id);
        for (int i = 0; i < VPA_OWNER_SLOTS; i++)
            if (ovalid[i] && otag[i] == id) return i;
        return -1;
    endfunction

    function automatic void remove_region(int idx);
        for (int i = idx; i + 1 < fcount; i++) begin
            fstart[i] = fstart[i + 1];
            flen[i]   = flen[i + 1];
        end
        fcount--;
    endfunction

    function automatic alloc_result_t allocate(logic [7:0] id, int size);
        alloc_result_t r;
        int pick, best, slot;
        bit found;
        r = '{ST_OK, '0, '0};
        pick = 0; best = 0; slot = -1; found = 0;
        if (find_owner(id) >= 0) begin
            r.status = ST_EXISTS;
            return r;
        end
        if (size == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        for (int i = 0; i < fcount; i++) begin
            if (flen[i] >= size && (!found || (policy == FIT_BEST && flen[i] - size < best)))
            begin
                found = 1;
                pick  = i;
                best  = flen[i] - size;
                if (policy == FIT_FIRST) break;
            end
        end
        if (!found) begin
            r.status = ST_NOFIT;
            return r;
        end
        for (int k = 0; k < VPA_OWNER_SLOTS; k++)
            if (!ovalid[k]) begin
                slot = k;
                break;
            end
        if (slot < 0) begin
            r.status = ST_FULL;
            return r;
        end
        r.start = 10'(fstart[pick]);
        r.size  = 11'(size);
        ovalid[slot] = 1;
        otag[slot]   = id;
        ostart[slot] = fstart[pick];
        olen[slot]   = size;
        if (flen[pick] == size) remove_region(pick);
        else begin
            fstart[pick] += size;
            flen[pick]   -= size;
        end
        return r;
    endfunction

    function automatic alloc_result_t release_block(logic [7:0] id);
        alloc_result_t r;
        int slot, s, n, p;
        bit lmerge, rmerge;
        r = '{ST_OK, '0, '0};
        slot = find_owner(id);
        if (slot < 0) begin
            r.status = ST_UNKNOWN;
            return r;
        end
        s = ostart[slot];
        n = olen[slot];
        p = 0;
        while (p < fcount && fstart[p] <= s) p++;
        lmerge = (p > 0) && (fstart[p - 1] + flen[p - 1] == s);
        rmerge = (p < fcount) && (s + n == fstart[p]);
        if (lmerge && rmerge) begin
            flen[p - 1] += n + flen[p];
            remove_region(p);
        end else if (lmerge) begin
            flen[p - 1] += n;
        end else if (rmerge) begin
            fstart[p] = s;
            flen[p]  += n;
        end else begin
            if (fcount >= VPA_FREE_SLOTS) begin
                r.status = ST_FULL;
                return r;
            end
            for (int i = fcount; i > p; i--) begin
                fstart[i] = fstart[i - 1];
                flen[i]   = flen[i - 1];
            end
            fstart[p] = s;
            flen[p]   = n;
            fcount++;
        end
        ovalid[slot] = 0;
        r.start = 10'(s);
        r.size  = 11'(n);
        return r;
    endfunction

    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            policy = FIT_FIRST;
            fcount = 1;
            fstart[0] = 0;
            flen[0]   = VPA_MEM_UNITS;
            for (int i = 0; i < VPA_OWNER_SLOTS; i++) ovalid[i] = 0;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) policy = cfg_wdata;
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_ALLOC)
                    expected_q = {expected_q,
                                  allocate(s_tdata[7:0], int'(s_tdata[18:8]))};
                else
                    expected_q = {expected_q, release_block(s_tdata[7:0])};
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[9:0] != want.start) begin
                        $error("block_start: expected %0d, got %0d", want.start,
                               m_tdata[9:0]);
                        fail_count++;
                    end
                    if (m_tdata[20:10] != want.size) begin
                        $error("block_size: expected %0d, got %0d", want.size,
                               m_tdata[20:10]);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// File: tb/variable_partition_allocator_unit_tb.sv
// Top of the allocator testbench: drives requests and fit policy changes,
// stalls the result stream, and gives the verdict.
// Depends on vpa_pkg, the allocator RTL and the checker module.
module variable_partition_allocator_unit_tb;
    import vpa_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    bit          calm = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    variable_partition_allocator_unit dut (.*);
    variable_partition_allocator_unit_checker chk (.*);

    // Watchdog: cycles without any transaction on either stream.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("variable_partition_allocator_unit_tb: errors");
            $finish;
        end
    end

    // Receiver stalls in bursts.
    always @(posedge aclk) begin
        int burst;
        if (!aresetn || calm) m_tready <= 1;
        else if (!m_tready) begin
            burst = $urandom_range(1, 7);
            repeat (burst - 1) @(posedge aclk);
            m_tready <= 1;
        end else if ($urandom_range(0, 5) == 0) m_tready <= 0;
    end

    // Valid stays high from one transaction to the next unless an idle gap
    // is taken; drain() drops it once the sender stops.
    task automatic send(logic op, logic [7:0] id, logic [10:0] size);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, size, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_policy(logic p);
        drain();
        cfg_we    <= 1;
        cfg_wdata <= p;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // Mostly a small id pool so releases find owners and tables fill up.
    task automatic random_phase(int count);
        logic [7:0] id;
        logic [10:0] size;
        for (int i = 0; i < count; i++) begin
            id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
            case ($urandom_range(0, 9))
                0:       size = 11'($urandom_range(0, 2047));
                1:       size = 11'($urandom_range(300, 1024));
                2:       size = 0;
                default: size = 11'($urandom_range(1, 96));
            endcase
            send(($urandom_range(0, 9) < 5) ? OP_ALLOC : OP_RELEASE, id, size);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        set_policy(FIT_FIRST);
        // Directed: whole memory, oversize, zero, duplicate, unknown, table full.
        send(OP_ALLOC, 8'hFF, 11'd1024);
        send(OP_ALLOC, 8'h00, 11'd1);
        send(OP_RELEASE, 8'hFF, 11'h7FF);
        send(OP_ALLOC, 8'h01, 11'd1025);
        send(OP_ALLOC, 8'h01, 11'h7FF);
        send(OP_ALLOC, 8'h02, 11'd0);
        send(OP_RELEASE, 8'h55, 11'd0);
        for (int i = 0; i < 16; i++) send(OP_ALLOC, 8'(8'h10 + i), 11'd10);
        send(OP_ALLOC, 8'h10, 11'd0);
        send(OP_ALLOC, 8'hAA, 11'd5);
        // Sender holds off until every result is back.
        drain();
        // Release pattern that covers the no-merge and the both-sides-merge cases.
        send(OP_RELEASE, 8'h12, 11'd0);
        send(OP_RELEASE, 8'h14, 11'd0);
        send(OP_RELEASE, 8'h13, 11'd0);
        send(OP_RELEASE, 8'h10, 11'd0);
        send(OP_RELEASE, 8'h11, 11'd0);
        set_policy(FIT_BEST);
        send(OP_ALLOC, 8'h20, 11'd10);
        random_phase(300);
        set_policy(FIT_FIRST);
        random_phase(250);
        set_policy(FIT_BEST);
        random_phase(200);
        calm = 1;
        random_phase(80);
        drain();
        if (fail_count == 0)
            $display("variable_partition_allocator_unit_tb: clean");
        else
            $display("variable_partition_allocator_unit_tb: errors");
        $finish;
    end
endmodule
